// File: rtl/ecbs_pkg.sv
// Shared types and constants for the event counter bank with sorted readout.
package ecbs_pkg;

  localparam int NumEventsDef = 64;
  localparam int CountBitsDef = 48;

  // Fixed widths of the stream payload fields.
  localparam int ActionW = 2;
  localparam int EventIdW = 8;
  localparam int InDataW = 16;
  localparam int OutIdW = 6;
  localparam int OutCntW = 48;
  localparam int OutDataW = 56;

  typedef enum logic [ActionW-1:0] {
    ACT_COUNT = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_DUMP  = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CNT_WR = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

  // Control that travels with one word read from the counter memory.
  typedef struct packed {
    logic vld;
    logic first;
  } cmp_ctl_t;

endpackage

// File: rtl/ecbs_cnt_mem.sv
// Counter memory with per-entry valid bits; an entry that is not valid reads as zero.
module ecbs_cnt_mem import ecbs_pkg::*; #(
  parameter int Depth = NumEventsDef,
  parameter int Width = CountBitsDef,
  parameter int AddrW = $clog2(NumEventsDef)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/ecbs_max_unit.sv
// Shared compare unit: finds the largest (count, id) key below a bound over one scan.
module ecbs_max_unit import ecbs_pkg::*; #(
  parameter int CountBits = CountBitsDef,
  parameter int IdxW = $clog2(NumEventsDef)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmp_ctl_t             ctl_i,
  input  logic [CountBits-1:0] cnt_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic                 have_bound_i,
  input  logic [CountBits-1:0] bound_cnt_i,
  input  logic [IdxW-1:0]      bound_idx_i,
  output logic                 found_o,
  output logic [CountBits-1:0] best_cnt_o,
  output logic [IdxW-1:0]      best_idx_o
);

  logic                 found_q;
  logic [CountBits-1:0] best_cnt_q;
  logic [IdxW-1:0]      best_idx_q;
  logic                 below_bound;
  logic                 beats_best;
  logic                 found_eff;
  logic                 take;

  // Keys are unique because ids are, so a strict compare orders ties by id.
  assign below_bound = !have_bound_i || ({cnt_i, idx_i} < {bound_cnt_i, bound_idx_i});
  assign found_eff   = found_q && !ctl_i.first;
  assign beats_best  = !found_eff || ({cnt_i, idx_i} > {best_cnt_q, best_idx_q});
  assign take        = ctl_i.vld && (cnt_i != '0) && below_bound && beats_best;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.vld) begin
      found_q <= found_eff || take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_cnt_q <= cnt_i;
      best_idx_q <= idx_i;
    end
  end

  assign found_o    = found_q;
  assign best_cnt_o = best_cnt_q;
  assign best_idx_o = best_idx_q;

endmodule

// File: rtl/event_counter_bank_sorted_readout.sv
// Top level of the event counter bank with sorted readout.
// Input words on s_axis carry an action and an event id. A count action bumps the
// saturating counter of that event (ids at or above NUM_EVENTS are dropped), a clear
// action zeroes all counters, and a dump action sends every nonzero counter out on
// m_axis as an (id, count) word, largest count first, higher id first on equal counts,
// with tlast on the final word. A dump of an all-zero bank sends one word with id 0,
// count 0 and tlast set.
// Flow: a count of an id in range reads the counter and writes it back in S_CNT_WR; a
// count of an id out of range, a clear and unused codes finish when accepted. A dump with
// n nonzero counters makes (n + 1) passes over the counter memory, because one compare
// unit walks the single memory read port once per word.
// s_axis_tready is low while an action is in progress. The output word sits in a
// register, so a new action is taken while the last word of a dump still waits; a
// stalled receiver holds the dump until that register frees up.
// Reset clears all counters at once through per-entry valid bits and empties the
// output register.
module event_counter_bank_sorted_readout import ecbs_pkg::*; #(
  parameter int NUM_EVENTS = NumEventsDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // action[1:0], event_id[9:2], zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // out_event_id[5:0], out_count[53:6], pad
  output logic                m_axis_tlast
);

  localparam int IdxW = $clog2(NUM_EVENTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_EVENTS - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic have_prev_q, have_prev_d;
  logic [COUNT_BITS-1:0] prev_cnt_q, prev_cnt_d;
  logic [IdxW-1:0] prev_idx_q, prev_idx_d;
  cmp_ctl_t cmp_ctl_q, cmp_ctl_d;
  logic [IdxW-1:0] rd_idx_q;

  logic m_valid_q;
  logic [OutIdW-1:0] out_id_q, out_id_d;
  logic [OutCntW-1:0] out_cnt_q, out_cnt_d;
  logic out_last_q, out_last_d;
  logic out_load;
  logic out_free;

  logic in_fire;
  logic [ActionW-1:0] in_action;
  logic [EventIdW-1:0] in_event;
  logic in_range;

  logic mem_clr, mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  logic best_found;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IdxW-1:0] best_idx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_action = s_axis_tdata[ActionW-1:0];
  assign in_event  = s_axis_tdata[ActionW+EventIdW-1:ActionW];
  assign in_range  = {1'b0, in_event} < (EventIdW + 1)'(NUM_EVENTS);
  assign out_free  = !m_valid_q || m_axis_tready;

  ecbs_cnt_mem #(
    .Depth (NUM_EVENTS),
    .Width (COUNT_BITS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ecbs_max_unit #(
    .CountBits (COUNT_BITS),
    .IdxW      (IdxW)
  ) u_max (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (cmp_ctl_q),
    .cnt_i        (mem_rdata),
    .idx_i        (rd_idx_q),
    .have_bound_i (have_prev_q),
    .bound_cnt_i  (prev_cnt_q),
    .bound_idx_i  (prev_idx_q),
    .found_o      (best_found),
    .best_cnt_o   (best_cnt),
    .best_idx_o   (best_idx)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    have_prev_d = have_prev_q;
    prev_cnt_d  = prev_cnt_q;
    prev_idx_d  = prev_idx_q;
    mem_clr     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = mem_rdata + COUNT_BITS'(1);
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    out_load    = 1'b0;
    out_id_d    = OutIdW'(prev_idx_q);
    out_cnt_d   = OutCntW'(prev_cnt_q);
    out_last_d  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_COUNT: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = IdxW'(in_event);
                addr_d    = IdxW'(in_event);
                state_d   = S_CNT_WR;
              end
            end
            ACT_CLEAR: begin
              mem_clr = 1'b1;
            end
            ACT_DUMP: begin
              have_prev_d = 1'b0;
              addr_d      = '0;
              state_d     = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_CNT_WR: begin
        // A counter that is all ones stays put.
        mem_we  = !(&mem_rdata);
        state_d = S_IDLE;
      end
      S_SCAN: begin
        mem_re = 1'b1;
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        // The previous pick is held back until the next pass shows whether it is last.
        if (best_found) begin
          if (!have_prev_q || out_free) begin
            out_load    = have_prev_q;
            have_prev_d = 1'b1;
            prev_cnt_d  = best_cnt;
            prev_idx_d  = best_idx;
            addr_d      = '0;
            state_d     = S_SCAN;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          if (!have_prev_q) begin
            out_id_d  = '0;
            out_cnt_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmp_ctl_d.vld   = (state_q == S_SCAN);
    cmp_ctl_d.first = (state_q == S_SCAN) && (addr_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      have_prev_q <= 1'b0;
      cmp_ctl_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      have_prev_q <= have_prev_d;
      cmp_ctl_q   <= cmp_ctl_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_cnt_q <= prev_cnt_d;
    prev_idx_q <= prev_idx_d;
    rd_idx_q   <= addr_q;
    if (out_load) begin
      out_id_q   <= out_id_d;
      out_cnt_q  <= out_cnt_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutCntW - OutIdW){1'b0}}, out_cnt_q, out_id_q};
  assign m_axis_tlast  = out_last_q;

endmodule
